@@ rtl/imupd_pkg.sv @@
// Package for the IMU packet deframer: packet layout constants, phase and
// status codes, and the frame check result type.
// No dependencies.
package imupd_pkg;

    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned STORE_D    = 16;
    localparam int unsigned INDEX_W    = 4;
    localparam int unsigned N_VALUES   = 6;

    localparam logic [7:0]         SYNC_BYTE  = 8'h55;
    localparam logic [COUNT_W-1:0] SUM_LEN    = 5'd16;
    localparam logic [COUNT_W-1:0] FIRST_DATA = 5'd2;
    localparam logic [INDEX_W-1:0] ID_INDEX   = 4'd3;
    localparam int unsigned        DATA_START = 4;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_SYNC1   = 2'd1,
        PH_COLLECT = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_GOOD   = 2'd0,
        ST_CKS_BAD = 2'd1,
        ST_ID_BAD = 2'd2
    } status_t;

    typedef struct packed {
        status_t                    status;
        logic [N_VALUES-1:0][15:0]  value;
    } frame_result_t;

endpackage

@@ rtl/imu_packet_deframer.sv @@
// Top level of the IMU packet deframer: sync hunt, byte collection with a
// running checksum, and the registered result channel.
// Depends on imupd_pkg and imupd_frame_check.
//
//  Channel   Direction  Handshake              Payload
//  s_        in         s_valid / s_ready      s_data_byte (one received byte)
//  m_        out        m_valid / m_ready      m_status and six signed values
//  cfg_      in         cfg_valid / cfg_ready  cfg_data (device_id)
//
// Every byte is handled in the cycle it is accepted, so the block takes one
// byte per clock; the result register is the only stage between the sides.
// A byte is accepted whenever the result register is empty or being drained
// in the same cycle, so a new transaction can follow a result without a gap.
// A stalled result holds off input only while m_valid is high and m_ready low.
// Reset (aresetn low, synchronous) returns to hunting and sets device_id to 0.
module imu_packet_deframer
    import imupd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [15:0] m_roll_angle,
    output logic signed [15:0] m_pitch_angle,
    output logic signed [15:0] m_yaw_angle,
    output logic signed [15:0] m_rate_x,
    output logic signed [15:0] m_rate_y,
    output logic signed [15:0] m_rate_z,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);

    // Control state.
    phase_t               phase_reg, phase_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [15:0]          sum_reg, sum_next;
    logic [7:0]           device_id_reg;
    logic                 m_valid_reg;

    // Payload storage; the packet store holds bytes of the current packet.
    logic [7:0]           packet_store [STORE_D];
    logic [7:0]           cks_low_reg;
    frame_result_t        result_reg;
    frame_result_t        check_result;

    logic                 in_accept;
    logic                 store_write;
    logic                 cks_low_write;
    logic                 emit;

    // The configuration register can always be written.
    assign cfg_ready = 1'b1;

    // Input is taken whenever the result register is free or being emptied.
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    // Next state of the deframer.
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        case (phase_reg)
            PH_COLLECT: begin
                if (count_reg < SUM_LEN) begin
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_reg + {8'h00, s_data_byte};
                end else if (count_reg == SUM_LEN) begin
                    count_next = count_reg + 1'b1;
                end else begin
                    // Last checksum byte: the packet is done, hunt again.
                    phase_next = PH_HUNT;
                    count_next = '0;
                    sum_next   = '0;
                end
            end
            PH_SYNC1: begin
                if (s_data_byte == SYNC_BYTE) begin
                    // The start word is the first two summed bytes.
                    phase_next = PH_COLLECT;
                    count_next = FIRST_DATA;
                    sum_next   = {7'h00, SYNC_BYTE, 1'b0};
                end else begin
                    phase_next = PH_HUNT;
                end
            end
            default: begin
                phase_next = (s_data_byte == SYNC_BYTE) ? PH_SYNC1 : PH_HUNT;
            end
        endcase
    end

    // Output decode of the deframer: which storage to write, and when a
    // result is produced.
    always_comb begin
        store_write   = 1'b0;
        cks_low_write = 1'b0;
        emit          = 1'b0;
        case (phase_reg)
            PH_COLLECT: begin
                if (count_reg < SUM_LEN) begin
                    store_write = in_accept;
                end else if (count_reg == SUM_LEN) begin
                    cks_low_write = in_accept;
                end else begin
                    emit = in_accept;
                end
            end
            default: begin
            end
        endcase
    end

    imupd_frame_check u_frame_check (
        .packet_store (packet_store),
        .device_id    (device_id_reg),
        .running_sum  (sum_reg),
        .received_sum ({s_data_byte, cks_low_reg}),
        .result       (check_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
            sum_reg   <= '0;
        end else if (in_accept) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_id_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            device_id_reg <= cfg_data;
        end
    end

    // Packet bytes land at their position in the packet.
    always_ff @(posedge aclk) begin
        if (store_write) begin
            packet_store[count_reg[INDEX_W-1:0]] <= s_data_byte;
        end
        if (cks_low_write) begin
            cks_low_reg <= s_data_byte;
        end
    end

    // Result register: loads on the last byte of a packet, clears when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            result_reg <= check_result;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = result_reg.status;
    assign m_roll_angle  = result_reg.value[0];
    assign m_pitch_angle = result_reg.value[1];
    assign m_yaw_angle   = result_reg.value[2];
    assign m_rate_x      = result_reg.value[3];
    assign m_rate_y      = result_reg.value[4];
    assign m_rate_z      = result_reg.value[5];

endmodule

@@ rtl/imupd_frame_check.sv @@
// Frame check for the IMU packet deframer: judges id and checksum of a
// complete packet and extracts the six little-endian 16-bit values.
// Depends on imupd_pkg.
module imupd_frame_check
    import imupd_pkg::*;
(
    input  logic [7:0]    packet_store [STORE_D],
    input  logic [7:0]    device_id,
    input  logic [15:0]   running_sum,
    input  logic [15:0]   received_sum,
    output frame_result_t result
);

    status_t status;

    // An id mismatch wins over a checksum mismatch.
    always_comb begin
        if (packet_store[ID_INDEX] != device_id) begin
            status = ST_ID_BAD;
        end else if (received_sum != running_sum) begin
            status = ST_CKS_BAD;
        end else begin
            status = ST_GOOD;
        end
    end

    assign result.status = status;

    for (genvar j = 0; j < N_VALUES; j++) begin : g_word
        localparam logic [INDEX_W-1:0] LO_IDX = INDEX_W'(DATA_START + 2 * j);
        localparam logic [INDEX_W-1:0] HI_IDX = INDEX_W'(DATA_START + 2 * j + 1);
        // Values are only passed on for a good packet.
        assign result.value[j] = (status == ST_GOOD) ?
                                 {packet_store[HI_IDX], packet_store[LO_IDX]} : 16'h0000;
    end

endmodule

@@ tb/sv/imu_packet_deframer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for imu_packet_deframer: directed and random byte streams,
// a cycle-free predictor of the deframer, and a scoreboard on the result channel.
// Depends on imupd_pkg and the imu_packet_deframer RTL.
module imu_packet_deframer_tb;
    import imupd_pkg::*;

    // Packet bytes on the wire: start word, channel, id, six values, checksum.
    localparam int PACKET_BYTES = 18;
    // Random bytes per traffic phase; five phases plus the directed rows make
    // roughly 1400 byte transactions.
    localparam int PHASE_BYTES  = 276;
    // The only stage between the sides is the result register, so a short
    // drain covers anything still in flight.
    localparam int DRAIN_CYCLES = 4;
    // Cycles without any transaction on any channel before the run is abandoned.
    localparam int QUIET_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 10;

    // Traffic pacing: who inserts bubbles, and how often (percent of cycles).
    typedef enum logic [1:0] {
        PACE_STREAM,
        PACE_SEND_GAPS,
        PACE_RECV_STALLS,
        PACE_BOTH
    } pace_t;

    typedef struct packed {
        logic [7:0]    data;
        bit            typed;
        frame_result_t want;
    } stim_row_t;

    // In frame_result_t the values are kept as roll, pitch, yaw, rate x, y, z
    // at indexes 0 to 5.
    localparam frame_result_t NO_RESULT    = '0;
    localparam frame_result_t EXTREME_GOOD = '{
        status: ST_GOOD,
        value:  {16'h8001, 16'h0001, 16'h5555, 16'hFFFF, 16'h8000, 16'h7FFF}
    };

    // Directed stream. A lone sync byte comes first and must be discarded.
    // Then a packet starting with three 0x55 bytes (the third is the channel),
    // id 0 to match the reset device_id, values at the signed extremes, and a
    // start word buried in rate x. Its byte sum is 0x0627.
    localparam stim_row_t DIRECTED_ROWS [20] = '{
        '{8'h55, 1'b0, NO_RESULT}, '{8'h12, 1'b0, NO_RESULT},
        '{8'h55, 1'b0, NO_RESULT}, '{8'h55, 1'b0, NO_RESULT},
        '{8'h55, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT}, '{8'h7F, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT}, '{8'h80, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
        '{8'h55, 1'b0, NO_RESULT}, '{8'h55, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT}, '{8'h80, 1'b0, NO_RESULT},
        '{8'h27, 1'b0, NO_RESULT}, '{8'h06, 1'b1, EXTREME_GOOD}
    };

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [7:0]         s_data_byte   = 8'h00;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [1:0]         m_status;
    logic signed [15:0] m_roll_angle;
    logic signed [15:0] m_pitch_angle;
    logic signed [15:0] m_yaw_angle;
    logic signed [15:0] m_rate_x;
    logic signed [15:0] m_rate_y;
    logic signed [15:0] m_rate_z;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_data      = 8'h00;

    // Predictor state: a mirror of the deframer, starting from its reset state.
    phase_t             hunt_phase    = PH_HUNT;
    logic [COUNT_W-1:0] held_count    = '0;
    logic [15:0]        byte_sum      = '0;
    logic [7:0]         frame_bytes [STORE_D];
    logic [7:0]         cks_low_byte  = 8'h00;
    logic [7:0]         device_id_cfg = 8'h00;

    frame_result_t      pending_frames [$];
    pace_t              pace          = PACE_STREAM;
    int                 bytes_sent    = 0;
    int                 mismatches    = 0;
    int                 quiet_cycles  = 0;

    imu_packet_deframer uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_roll_angle  (m_roll_angle),
        .m_pitch_angle (m_pitch_angle),
        .m_yaw_angle   (m_yaw_angle),
        .m_rate_x      (m_rate_x),
        .m_rate_y      (m_rate_y),
        .m_rate_z      (m_rate_z),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Advances the predictor by one accepted byte. Returns 1 when the byte
    // completes a packet, with the expected result in frame.
    function automatic bit deframe_byte(input logic [7:0] b, output frame_result_t frame);
        logic [15:0] received;
        frame = '0;
        case (hunt_phase)
            PH_COLLECT: begin
                if (held_count < SUM_LEN) begin
                    // Every byte counts while collecting, sync bytes included.
                    frame_bytes[held_count[INDEX_W-1:0]] = b;
                    byte_sum   = byte_sum + 16'(b);
                    held_count = held_count + 1'b1;
                end else if (held_count == SUM_LEN) begin
                    cks_low_byte = b;
                    held_count   = SUM_LEN + 1'b1;
                end else begin
                    // Last byte: a wrong id outranks a wrong checksum, and only
                    // a good packet carries its values.
                    received = {b, cks_low_byte};
                    if (frame_bytes[ID_INDEX] != device_id_cfg) begin
                        frame.status = ST_ID_BAD;
                    end else if (received != byte_sum) begin
                        frame.status = ST_CKS_BAD;
                    end else begin
                        frame.status = ST_GOOD;
                        for (int j = 0; j < N_VALUES; j++) begin
                            frame.value[j] = {frame_bytes[DATA_START + 2 * j + 1],
                                              frame_bytes[DATA_START + 2 * j]};
                        end
                    end
                    hunt_phase = PH_HUNT;
                    held_count = '0;
                    byte_sum   = '0;
                    return 1'b1;
                end
            end
            PH_SYNC1: begin
                if (b == SYNC_BYTE) begin
                    frame_bytes[0] = SYNC_BYTE;
                    frame_bytes[1] = SYNC_BYTE;
                    held_count     = FIRST_DATA;
                    byte_sum       = 16'(2 * SYNC_BYTE);
                    hunt_phase     = PH_COLLECT;
                end else begin
                    // A lone sync byte is dropped; this byte cannot start a
                    // packet itself.
                    hunt_phase = PH_HUNT;
                end
            end
            default: begin
                // Hunting, and the unused phase code that behaves the same way.
                hunt_phase = (b == SYNC_BYTE) ? PH_SYNC1 : PH_HUNT;
            end
        endcase
        return 1'b0;
    endfunction

    // Byte values weighted toward the edges of the signed range and the sync value.
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            4:       return SYNC_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Offers one byte on the input channel and waits for the transaction.
    // Called just after a rising edge. Valid is only lowered for a sender
    // bubble, so it is never dropped and raised again in the same step.
    // A typed row replaces the predicted result with the one given in the table.
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input frame_result_t want = '0);
        frame_result_t predicted;
        int            gap_pct;
        gap_pct = (pace == PACE_SEND_GAPS) ? 57 : (pace == PACE_BOTH) ? 22 : 0;
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        if (deframe_byte(b, predicted)) begin
            pending_frames.push_back(typed ? want : predicted);
        end
    endtask

    // Sends a well-formed packet for the current device_id, optionally with
    // a corrupted checksum or a wrong id.
    task automatic send_packet(input bit bad_cks, input bit bad_id);
        logic [7:0]  pkt [PACKET_BYTES];
        logic [15:0] sum;
        pkt[0] = SYNC_BYTE;
        pkt[1] = SYNC_BYTE;
        pkt[2] = rand_byte();
        pkt[3] = bad_id ? device_id_cfg ^ 8'($urandom_range(255, 1)) : device_id_cfg;
        for (int i = 4; i < 16; i++) pkt[i] = rand_byte();
        sum = '0;
        for (int i = 0; i < 16; i++) sum = sum + 16'(pkt[i]);
        if (bad_cks) sum = sum ^ 16'($urandom_range(65535, 1));
        pkt[16] = sum[7:0];
        pkt[17] = sum[15:8];
        for (int i = 0; i < PACKET_BYTES; i++) send_byte(pkt[i]);
    endtask

    // Configuration write transaction; called only while the block is idle.
    task automatic write_device_id(input logic [7:0] id);
        cfg_valid <= 1'b1;
        cfg_data  <= id;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid     <= 1'b0;
        device_id_cfg  = id;
    endtask

    // Result channel: scoreboard against the oldest expected frame, random
    // back-pressure, and the watchdog on channel activity.
    always @(posedge aclk) begin : result_monitor
        frame_result_t    want;
        logic [5:0][15:0] seen;
        bit               wrong;
        int               stall_pct;
        if (aresetn && m_valid && m_ready) begin
            seen = {m_rate_z, m_rate_y, m_rate_x, m_yaw_angle, m_pitch_angle, m_roll_angle};
            if (pending_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected result: status %0d values %h", m_status, seen);
                end
            end else begin
                want  = pending_frames.pop_front();
                wrong = (m_status !== want.status);
                for (int j = 0; j < N_VALUES; j++) begin
                    if (seen[j] !== want.value[j]) wrong = 1'b1;
                end
                if (wrong) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("result mismatch: expected status %0d values %h, got status %0d values %h",
                                 want.status, want.value, m_status, seen);
                    end
                end
            end
        end

        stall_pct = (pace == PACE_RECV_STALLS) ? 57 : (pace == PACE_BOTH) ? 22 : 0;
        m_ready  <= ($urandom_range(99) >= stall_pct);

        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus: reset, the directed table with the reset device_id, then five
    // random phases, each with its own device_id and pacing.
    initial begin
        pace_t      phase_pace [5];
        logic [7:0] phase_ids  [5];
        logic [7:0] b;
        int         phase_end;
        int         choice;
        int         k;

        phase_pace = '{PACE_STREAM, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH, PACE_STREAM};
        phase_ids  = '{8'hFF, 8'h00, 8'($urandom_range(255)), 8'h55, 8'($urandom_range(255))};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
            send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end

        for (int p = 0; p < 5; p++) begin
            // Let the block go quiet before touching device_id: no packet in
            // progress, no result outstanding, and a drain margin on top.
            s_valid <= 1'b0;
            while (pending_frames.size() != 0) @(posedge aclk);
            repeat (DRAIN_CYCLES) @(posedge aclk);
            write_device_id(phase_ids[p]);
            pace      = phase_pace[p];
            phase_end = bytes_sent + PHASE_BYTES;

            // Each phase opens with a bad checksum and a wrong id, then mostly
            // well-formed packets, with lone sync bytes, noise and cut-off
            // packets mixed in to test resynchronization.
            k = 0;
            while (bytes_sent < phase_end) begin
                choice = (k == 0) ? 75 : (k == 1) ? 85 : int'($urandom_range(99));
                k++;
                if (choice < 70) begin
                    send_packet(1'b0, 1'b0);
                end else if (choice < 80) begin
                    send_packet(1'b1, 1'b0);
                end else if (choice < 88) begin
                    send_packet(1'($urandom_range(1)), 1'b1);
                end else if (choice < 93) begin
                    b = 8'($urandom_range(255));
                    if (b == SYNC_BYTE) b = ~b;
                    send_byte(SYNC_BYTE);
                    send_byte(b);
                end else if (choice < 97) begin
                    repeat ($urandom_range(6, 1)) begin
                        send_byte(($urandom_range(3) == 0) ? SYNC_BYTE : 8'($urandom_range(255)));
                    end
                end else begin
                    // A packet cut short: the following traffic gets absorbed.
                    send_byte(SYNC_BYTE);
                    send_byte(SYNC_BYTE);
                    repeat ($urandom_range(15)) send_byte(rand_byte());
                end
            end

            // Finish any packet the stream left open so the block ends idle.
            while (hunt_phase != PH_HUNT) begin
                send_byte((hunt_phase == PH_SYNC1) ? 8'h00 : rand_byte());
            end
        end

        s_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_frames.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
